### hw/rtl/day_time_accumulator_macros.svh
// Assertion macros used by the checker file.
`ifndef DAY_TIME_ACCUMULATOR_MACROS_SVH
`define DAY_TIME_ACCUMULATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTA_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("day_time_accumulator: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DTA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("day_time_accumulator: assertion failed");

`endif

### hw/rtl/dta_pkg.sv
`default_nettype none

package dta_pkg;

    localparam int DAYS_W    = 15;
    localparam int FIELD_W   = 7;
    localparam int TOTAL_W   = 26;
    localparam int MODE_W    = 2;

    // Working widths: a sum of a stored field and an input, plus carries.
    localparam int SEC_W     = 8;
    localparam int NORM_W    = 9;
    localparam int DAYS_SUM_W = 17;
    localparam int RADIX_W   = 6;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 64;

    localparam logic [RADIX_W-1:0] SECS_PER_MIN  = 6'd60;
    localparam logic [RADIX_W-1:0] MINS_PER_HOUR = 6'd60;
    localparam logic [RADIX_W-1:0] DAY_HOURS     = 6'd24;
    localparam logic [10:0]        MINS_PER_DAY  = 11'd1440;
    localparam logic [DAYS_W-1:0]  DAYS_MAX      = 15'd32767;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADVANCE = 2'd0,
        MODE_SET     = 2'd1,
        MODE_READ    = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_TOTAL
    } state_t;

    typedef struct packed {
        logic                ge;
        logic [NORM_W-1:0]   diff;
    } norm_res_t;

endpackage

`default_nettype wire

### hw/rtl/dta_norm_unit.sv
`default_nettype none

// Compare-and-subtract step used for every carry of the clock.
module dta_norm_unit (
    input  wire logic [dta_pkg::NORM_W-1:0]  value,
    input  wire logic [dta_pkg::RADIX_W-1:0] radix,
    output dta_pkg::norm_res_t               res
);

    logic [dta_pkg::NORM_W:0] diff_full;

    assign diff_full = {1'b0, value} - {{(dta_pkg::NORM_W + 1 - dta_pkg::RADIX_W){1'b0}}, radix};
    assign res.ge    = ~diff_full[dta_pkg::NORM_W];
    assign res.diff  = diff_full[dta_pkg::NORM_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/day_time_accumulator.sv
// Clock of days, hours, minutes and seconds. Each input beat carries a mode in s_tuser
// (advance, set, or read) and four amounts in s_tdata; every beat yields one result beat
// with the stored time and the total minute count. A read, set or unused mode goes
// from acceptance to ST_TOTAL, which loads the result register once the output is free.
// An advance adds on acceptance, then works each carry in ST_SEC, ST_MIN and ST_HOUR
// through a single compare-and-subtract unit, and forms the minute total in ST_TOTAL.
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register and does not hold up the next input beat.
`default_nettype none

module day_time_accumulator (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // days_in[14:0], hours_in[21:15], minutes_in[28:22], seconds_in[35:29], zero pad
    input  wire logic [dta_pkg::S_TDATA_W-1:0]  s_tdata,
    // mode[1:0]
    input  wire logic [dta_pkg::MODE_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // days_out[14:0], hours_out[21:15], minutes_out[28:22], seconds_out[35:29],
    // minute_total[61:36], zero pad
    output logic [dta_pkg::M_TDATA_W-1:0]       m_tdata
);

    dta_pkg::state_t state_reg, state_next;

    logic [dta_pkg::SEC_W-1:0]      sec_reg, sec_next;
    logic [dta_pkg::NORM_W-1:0]     min_reg, min_next;
    logic [dta_pkg::NORM_W-1:0]     hr_reg, hr_next;
    logic [dta_pkg::DAYS_SUM_W-1:0] day_reg, day_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [dta_pkg::M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [dta_pkg::DAYS_W-1:0]     days_in;
    logic [dta_pkg::FIELD_W-1:0]    hours_in, minutes_in, seconds_in;
    dta_pkg::mode_t                 mode;

    logic [dta_pkg::NORM_W-1:0]     unit_value;
    logic [dta_pkg::RADIX_W-1:0]    unit_radix;
    dta_pkg::norm_res_t             unit_res;

    logic                           s_accept;
    logic                           out_free;
    logic [dta_pkg::TOTAL_W-1:0]    total_calc;
    logic [dta_pkg::DAYS_W-1:0]     day_sat;

    assign days_in    = s_tdata[14:0];
    assign hours_in   = s_tdata[21:15];
    assign minutes_in = s_tdata[28:22];
    assign seconds_in = s_tdata[35:29];
    assign mode       = dta_pkg::mode_t'(s_tuser);

    assign s_tready = (state_reg == dta_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        unique case (state_reg)
            dta_pkg::ST_SEC: begin
                unit_value = {1'b0, sec_reg};
                unit_radix = dta_pkg::SECS_PER_MIN;
            end
            dta_pkg::ST_MIN: begin
                unit_value = min_reg;
                unit_radix = dta_pkg::MINS_PER_HOUR;
            end
            default: begin
                unit_value = hr_reg;
                unit_radix = dta_pkg::DAY_HOURS;
            end
        endcase
    end

    dta_norm_unit u_norm (
        .value (unit_value),
        .radix (unit_radix),
        .res   (unit_res)
    );

    // Anything at or beyond bit 15 means the day count went past its limit.
    assign day_sat = (day_reg[dta_pkg::DAYS_SUM_W-1:dta_pkg::DAYS_W] != '0)
                   ? dta_pkg::DAYS_MAX : day_reg[dta_pkg::DAYS_W-1:0];

    assign total_calc = dta_pkg::TOTAL_W'(day_reg[dta_pkg::DAYS_W-1:0])
                          * dta_pkg::TOTAL_W'(dta_pkg::MINS_PER_DAY)
                      + dta_pkg::TOTAL_W'(hr_reg) * dta_pkg::TOTAL_W'(dta_pkg::MINS_PER_HOUR)
                      + dta_pkg::TOTAL_W'(min_reg);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dta_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (mode == dta_pkg::MODE_ADVANCE) begin
                        state_next = dta_pkg::ST_SEC;
                    end else begin
                        state_next = dta_pkg::ST_TOTAL;
                    end
                end
            end
            dta_pkg::ST_SEC: begin
                if (!unit_res.ge) begin
                    state_next = dta_pkg::ST_MIN;
                end
            end
            dta_pkg::ST_MIN: begin
                if (!unit_res.ge) begin
                    state_next = dta_pkg::ST_HOUR;
                end
            end
            dta_pkg::ST_HOUR: begin
                if (!unit_res.ge) begin
                    state_next = dta_pkg::ST_TOTAL;
                end
            end
            dta_pkg::ST_TOTAL: begin
                if (out_free) begin
                    state_next = dta_pkg::ST_IDLE;
                end
            end
            default: state_next = dta_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb begin
        sec_next      = sec_reg;
        min_next      = min_reg;
        hr_next       = hr_reg;
        day_next      = day_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            dta_pkg::ST_IDLE: begin
                if (s_accept) begin
                    priority case (mode)
                        dta_pkg::MODE_ADVANCE: begin
                            sec_next = sec_reg + dta_pkg::SEC_W'(seconds_in);
                            min_next = min_reg + dta_pkg::NORM_W'(minutes_in);
                            hr_next  = hr_reg + dta_pkg::NORM_W'(hours_in);
                            day_next = day_reg + dta_pkg::DAYS_SUM_W'(days_in);
                        end
                        dta_pkg::MODE_SET: begin
                            sec_next = dta_pkg::SEC_W'(seconds_in);
                            min_next = dta_pkg::NORM_W'(minutes_in);
                            hr_next  = dta_pkg::NORM_W'(hours_in);
                            day_next = dta_pkg::DAYS_SUM_W'(days_in);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            dta_pkg::ST_SEC: begin
                if (unit_res.ge) begin
                    sec_next = unit_res.diff[dta_pkg::SEC_W-1:0];
                    min_next = min_reg + dta_pkg::NORM_W'(1);
                end
            end
            dta_pkg::ST_MIN: begin
                if (unit_res.ge) begin
                    min_next = unit_res.diff;
                    hr_next  = hr_reg + dta_pkg::NORM_W'(1);
                end
            end
            dta_pkg::ST_HOUR: begin
                if (unit_res.ge) begin
                    hr_next  = unit_res.diff;
                    day_next = day_reg + dta_pkg::DAYS_SUM_W'(1);
                end else begin
                    day_next = dta_pkg::DAYS_SUM_W'(day_sat);
                end
            end
            dta_pkg::ST_TOTAL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00,
                                     total_calc,
                                     sec_reg[dta_pkg::FIELD_W-1:0],
                                     min_reg[dta_pkg::FIELD_W-1:0],
                                     hr_reg[dta_pkg::FIELD_W-1:0],
                                     day_reg[dta_pkg::DAYS_W-1:0]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dta_pkg::ST_IDLE;
            sec_reg      <= '0;
            min_reg      <= '0;
            hr_reg       <= '0;
            day_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            hr_reg       <= hr_next;
            day_reg      <= day_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

### hw/rtl/day_time_accumulator_chk.sv
`default_nettype none
`include "day_time_accumulator_macros.svh"

module day_time_accumulator_chk (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [dta_pkg::M_TDATA_W-1:0] m_tdata
);

    logic [dta_pkg::TOTAL_W-1:0] total_expect;

    assign total_expect = dta_pkg::TOTAL_W'(m_tdata[14:0]) * dta_pkg::TOTAL_W'(dta_pkg::MINS_PER_DAY)
                        + dta_pkg::TOTAL_W'(m_tdata[21:15])
                          * dta_pkg::TOTAL_W'(dta_pkg::MINS_PER_HOUR)
                        + dta_pkg::TOTAL_W'(m_tdata[28:22]);

    // A stalled result stays offered and unchanged.
    `DTA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `DTA_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // Accepting an item takes the sequencer out of idle, so the input closes.
    `DTA_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // The minute total always agrees with the day, hour and minute fields beside it.
    `DTA_ASSERT_NOW(a_total_matches, aclk, aresetn, m_tvalid, m_tdata[61:36] == total_expect)

endmodule

bind day_time_accumulator day_time_accumulator_chk u_chk (.*);

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 50;

    typedef struct {
        dta_pkg::mode_t                     mode;
        logic [dta_pkg::DAYS_W-1:0]         days;
        logic [dta_pkg::FIELD_W-1:0]        hours;
        logic [dta_pkg::FIELD_W-1:0]        minutes;
        logic [dta_pkg::FIELD_W-1:0]        seconds;
        int                                 gap;
        bit                                 hold;
    } time_cmd_t;

    typedef struct {
        logic [dta_pkg::DAYS_W-1:0]  days;
        logic [dta_pkg::FIELD_W-1:0] hours;
        logic [dta_pkg::FIELD_W-1:0] minutes;
        logic [dta_pkg::FIELD_W-1:0] seconds;
        logic [dta_pkg::TOTAL_W-1:0] total;
    } time_reading_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [dta_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic [dta_pkg::MODE_W-1:0]     s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [dta_pkg::M_TDATA_W-1:0]  m_tdata;

    time_cmd_t     pending_cmds[$];
    time_reading_t expected_readings[$];
    time_cmd_t     cur_cmd;

    // Time of day as the block should hold it.
    logic [dta_pkg::DAYS_W-1:0] tod_days = '0;
    logic [7:0]                 tod_hours = '0;
    logic [7:0]                 tod_minutes = '0;
    logic [7:0]                 tod_seconds = '0;

    int  n_cmds;
    int  accepted_cnt = 0;
    int  error_cnt = 0;
    int  cycle_cnt = 0;
    int  wait_left = 0;
    int  stall_left = 0;
    bit  tx_calm = 1'b1;
    bit  rx_calm = 1'b1;

    day_time_accumulator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic time_reading_t step_time_of_day(time_cmd_t c);
        int unsigned   sec;
        int unsigned   mins;
        int unsigned   hrs;
        int unsigned   dys;
        int unsigned   total;
        time_reading_t r;
        if (c.mode == dta_pkg::MODE_ADVANCE) begin
            sec  = tod_seconds + c.seconds;
            mins = tod_minutes + c.minutes;
            hrs  = tod_hours + c.hours;
            dys  = tod_days + c.days;
            mins += sec / dta_pkg::SECS_PER_MIN;
            sec  %= dta_pkg::SECS_PER_MIN;
            hrs  += mins / dta_pkg::MINS_PER_HOUR;
            mins %= dta_pkg::MINS_PER_HOUR;
            dys  += hrs / dta_pkg::DAY_HOURS;
            hrs  %= dta_pkg::DAY_HOURS;
            if (dys > dta_pkg::DAYS_MAX) begin
                dys = dta_pkg::DAYS_MAX;
            end
            tod_seconds = 8'(sec);
            tod_minutes = 8'(mins);
            tod_hours   = 8'(hrs);
            tod_days    = dta_pkg::DAYS_W'(dys);
        end else if (c.mode == dta_pkg::MODE_SET) begin
            tod_days    = c.days;
            tod_hours   = {1'b0, c.hours};
            tod_minutes = {1'b0, c.minutes};
            tod_seconds = {1'b0, c.seconds};
        end
        total = 32'(dta_pkg::MINS_PER_DAY) * tod_days
              + 32'(dta_pkg::MINS_PER_HOUR) * tod_hours + tod_minutes;
        r.days    = tod_days;
        r.hours   = tod_hours[dta_pkg::FIELD_W-1:0];
        r.minutes = tod_minutes[dta_pkg::FIELD_W-1:0];
        r.seconds = tod_seconds[dta_pkg::FIELD_W-1:0];
        r.total   = dta_pkg::TOTAL_W'(total);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_cnt++;
        end
    endfunction

    function automatic void add_cmd(dta_pkg::mode_t mode, int unsigned d, int unsigned h,
                                    int unsigned m, int unsigned s, bit hold);
        time_cmd_t c;
        if ($urandom_range(0, 29) == 0) begin
            tx_calm = !tx_calm;
        end
        c.mode    = mode;
        c.days    = dta_pkg::DAYS_W'(d);
        c.hours   = dta_pkg::FIELD_W'(h);
        c.minutes = dta_pkg::FIELD_W'(m);
        c.seconds = dta_pkg::FIELD_W'(s);
        c.gap     = tx_calm ? 0 : $urandom_range(0, 9);
        c.hold    = hold;
        pending_cmds.push_back(c);
    endfunction

    // Sender: one beat at a time from the pending list, with a drawn gap before each beat after the first.
    always @(posedge aclk) begin : sender
        bit nxt_valid;
        nxt_valid = s_tvalid && !s_tready;
        if (s_tvalid && s_tready) begin
            expected_readings.push_back(step_time_of_day(cur_cmd));
            accepted_cnt++;
            if (pending_cmds.size() > 0) begin
                wait_left = pending_cmds[0].gap;
            end
        end
        if (aresetn && !nxt_valid && pending_cmds.size() > 0) begin
            if (wait_left > 0) begin
                wait_left--;
            end else if (!pending_cmds[0].hold || expected_readings.size() == 0) begin
                cur_cmd = pending_cmds.pop_front();
                s_tdata <= {4'b0, cur_cmd.seconds, cur_cmd.minutes, cur_cmd.hours,
                            cur_cmd.days};
                s_tuser <= cur_cmd.mode;
                nxt_valid = 1'b1;
            end
        end
        s_tvalid <= nxt_valid;
    end

    // Receiver: checks each result beat against the oldest prediction.
    always @(posedge aclk) begin : receiver
        time_reading_t want;
        bit            nxt_ready;
        if (m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_tdata);
                error_cnt++;
            end else begin
                want = expected_readings.pop_front();
                check_field("days_out", want.days, m_tdata[14:0]);
                check_field("hours_out", want.hours, m_tdata[21:15]);
                check_field("minutes_out", want.minutes, m_tdata[28:22]);
                check_field("seconds_out", want.seconds, m_tdata[35:29]);
                check_field("minute_total", want.total, m_tdata[61:36]);
            end
            if ($urandom_range(0, 29) == 0) begin
                rx_calm = !rx_calm;
            end
            stall_left = rx_calm ? 0 : $urandom_range(0, 9);
        end
        if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
        end else begin
            nxt_ready = 1'b1;
        end
        m_tready <= aresetn && nxt_ready;
    end

    initial begin
        int pick;
        int unsigned d;
        // Directed: reset state, extremes, carries, saturation and loose sets.
        add_cmd(dta_pkg::MODE_READ, 0, 0, 0, 0, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 0, 0, 0, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 32767, 127, 127, 127, 1'b0);
        add_cmd(dta_pkg::MODE_SET, 0, 0, 0, 0, 1'b0);
        add_cmd(dta_pkg::MODE_SET, 32767, 127, 127, 127, 1'b1);
        add_cmd(dta_pkg::MODE_READ, 32767, 127, 127, 127, 1'b0);
        add_cmd(dta_pkg::MODE_UNUSED, 0, 0, 0, 0, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 0, 0, 0, 1'b0);
        add_cmd(dta_pkg::MODE_SET, 0, 0, 0, 0, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 0, 0, 59, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 0, 0, 1, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 0, 59, 0, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 23, 0, 0, 1'b0);
        add_cmd(dta_pkg::MODE_SET, 5, 23, 59, 59, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 0, 0, 1, 1'b0);
        add_cmd(dta_pkg::MODE_SET, 32766, 23, 59, 59, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 0, 0, 1, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 0, 0, 1, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 24, 0, 0, 1'b0);
        add_cmd(dta_pkg::MODE_SET, 15'h5555, 7'h2a, 7'h2a, 7'h2a, 1'b0);
        add_cmd(dta_pkg::MODE_SET, 15'h2aaa, 7'h55, 7'h55, 7'h55, 1'b0);
        add_cmd(dta_pkg::MODE_SET, 100, 12, 30, 30, 1'b0);
        add_cmd(dta_pkg::MODE_ADVANCE, 0, 127, 127, 127, 1'b0);
        add_cmd(dta_pkg::MODE_UNUSED, 32767, 127, 127, 127, 1'b0);

        for (int i = 0; i < 630; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                add_cmd(dta_pkg::MODE_ADVANCE, $urandom_range(0, 3), $urandom_range(0, 30),
                        $urandom_range(0, 70), $urandom_range(0, 70), i == 300);
            end else if (pick < 50) begin
                d = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 9);
                add_cmd(dta_pkg::MODE_ADVANCE, d, $urandom_range(0, 127),
                        $urandom_range(0, 127), $urandom_range(0, 127), i == 300);
            end else if (pick < 65) begin
                // Normalised sets, often close to the day limit.
                d = ($urandom_range(0, 3) == 0) ? $urandom_range(32760, 32767)
                                                : $urandom_range(0, 32767);
                add_cmd(dta_pkg::MODE_SET, d, $urandom_range(0, 23), $urandom_range(0, 59),
                        $urandom_range(0, 59), i == 300);
            end else if (pick < 75) begin
                add_cmd(dta_pkg::MODE_SET, $urandom_range(0, 32767), $urandom_range(0, 127),
                        $urandom_range(0, 127), $urandom_range(0, 127), i == 300);
            end else if (pick < 90) begin
                add_cmd(dta_pkg::MODE_READ, $urandom_range(0, 32767), $urandom_range(0, 127),
                        $urandom_range(0, 127), $urandom_range(0, 127), i == 300);
            end else begin
                add_cmd(dta_pkg::MODE_UNUSED, $urandom_range(0, 32767),
                        $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 127), i == 300);
            end
        end
        n_cmds = pending_cmds.size();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(accepted_cnt == n_cmds && expected_readings.size() == 0)
               && cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge aclk);
            if (error_cnt == 0) begin
                $display("simulation ok");
            end else begin
                $display("simulation failed");
            end
        end
        $finish;
    end

endmodule

`default_nettype wire
